### design/mas_pkg.sv
// Shared types, constants and control structs of the moving-average block.
`timescale 1ns / 1ps

package mas_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int COUNT_BITS     = 16;
	localparam int TOTAL_BITS     = SAMPLE_BITS + COUNT_BITS;
	localparam int CFG_BITS       = 7;
	localparam int WINDOW_MAX_DEF = 64;
	localparam int WS_RESET       = 3;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          batch_end;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] average;
		logic                          average_valid;
		logic signed [SAMPLE_BITS-1:0] batch_min;
		logic signed [SAMPLE_BITS-1:0] batch_max;
		logic signed [SAMPLE_BITS-1:0] batch_mean;
		logic                          stats_valid;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_START_AVG,
		ST_DIV_AVG,
		ST_RECORD,
		ST_START_MEAN,
		ST_DIV_MEAN,
		ST_EMIT
	} mas_state_t;

	typedef struct packed {
		logic load_item;
		logic cfg_write;
		logic update;
		logic div_start;
		logic div_mean;
		logic record;
		logic emit;
	} mas_cmd_t;

	typedef struct packed {
		logic produce;
		logic last;
		logic div_done;
		logic out_free;
	} mas_status_t;

endpackage

### design/mas_div.sv
// Shared restoring divider: signed dividend by unsigned divisor, one quotient bit per cycle.
`timescale 1ns / 1ps

module mas_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [mas_pkg::TOTAL_BITS-1:0] dividend,
	input  logic        [mas_pkg::COUNT_BITS-1:0] divisor,
	output logic                                 done,
	output logic signed [mas_pkg::SAMPLE_BITS-1:0] quotient
);
	import mas_pkg::*;

	localparam int CNT_W = $clog2(TOTAL_BITS);

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [COUNT_BITS-1:0]   rem_q;
	logic [TOTAL_BITS-1:0]   quo_q;
	logic [COUNT_BITS-1:0]   dvs_q;
	logic                    neg_q;
	logic [COUNT_BITS:0]     trial;
	logic                    fits;
	logic [TOTAL_BITS-1:0]   mag;
	logic [TOTAL_BITS-1:0]   quo_signed;

	assign mag   = dividend[TOTAL_BITS-1] ? (~dividend + 1'b1) : dividend;
	assign trial = {rem_q, quo_q[TOTAL_BITS-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(TOTAL_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag;
			dvs_q <= divisor;
			neg_q <= dividend[TOTAL_BITS-1];
		end else if (busy_q) begin
			rem_q <= fits ? COUNT_BITS'(trial - {1'b0, dvs_q}) : trial[COUNT_BITS-1:0];
			quo_q <= {quo_q[TOTAL_BITS-2:0], fits};
		end
	end

	// Truncation toward zero: divide magnitudes, then restore the sign.
	assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign quotient   = quo_signed[SAMPLE_BITS-1:0];
	assign done       = done_q;

endmodule

### design/mas_datapath.sv
// Datapath: sample ring, window sum, batch statistics, divider and result register.
`timescale 1ns / 1ps

module mas_datapath #(
	parameter int WINDOW_MAX = mas_pkg::WINDOW_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mas_pkg::mas_cmd_t             cmd,
	output mas_pkg::mas_status_t          status,
	input  mas_pkg::item_t                item,
	input  logic [mas_pkg::CFG_BITS-1:0]  cfg_data,
	input  logic                          result_ready,
	output logic                          result_valid,
	output mas_pkg::result_t              result
);
	import mas_pkg::*;

	localparam int WS_BITS = $clog2(WINDOW_MAX + 1);
	localparam int AW      = $clog2(WINDOW_MAX);
	localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_MAX);
	localparam int CMP_W   = (WS_BITS > CFG_BITS) ? WS_BITS : CFG_BITS;
	localparam int WS_RST  = (WS_RESET > WINDOW_MAX) ? WINDOW_MAX : WS_RESET;

	logic signed [SAMPLE_BITS-1:0] store_mem [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] old_sample_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          last_q;
	logic [WS_BITS-1:0]            ws_q;
	logic [WS_BITS-1:0]            fill_q;
	logic [AW-1:0]                 wp_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [SAMPLE_BITS-1:0] avg_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic signed [TOTAL_BITS-1:0]  total_q;
	logic [COUNT_BITS-1:0]         count_q;
	logic                          result_valid_q;
	result_t                       result_q;

	logic                          full;
	logic [WS_BITS-1:0]            fill_inc;
	logic [WS_BITS-1:0]            wp_inc;
	logic [CMP_W-1:0]              cfg_ext;
	logic [WS_BITS-1:0]            ws_new;
	logic                          clear;
	logic signed [TOTAL_BITS-1:0]  div_dividend;
	logic [COUNT_BITS-1:0]         div_divisor;
	logic                          div_done;
	logic signed [SAMPLE_BITS-1:0] div_quotient;
	logic                          out_free;

	assign full     = fill_q == ws_q;
	assign fill_inc = fill_q + 1'b1;
	assign wp_inc   = WS_BITS'(wp_q) + 1'b1;
	assign cfg_ext  = CMP_W'(cfg_data);
	assign out_free = !result_valid_q || result_ready;
	assign clear    = cmd.cfg_write || (cmd.emit && last_q);

	always_comb begin
		if (cfg_ext == '0) begin
			ws_new = WS_BITS'(1);
		end else if (cfg_ext > CMP_W'(WINDOW_MAX)) begin
			ws_new = WS_BITS'(WINDOW_MAX);
		end else begin
			ws_new = WS_BITS'(cfg_ext);
		end
	end

	// The ring is read every cycle at the write pointer, so the oldest sample is
	// ready in the cycle after an item is taken.
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			store_mem[wp_q] <= sample_q;
		end
		old_sample_q <= store_mem[wp_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			sample_q <= item.sample;
			last_q   <= item.batch_end;
		end
		if (cmd.record) begin
			avg_q <= div_quotient;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q    <= WS_BITS'(WS_RST);
			fill_q  <= '0;
			wp_q    <= '0;
			sum_q   <= '0;
			min_q   <= '0;
			max_q   <= '0;
			total_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.cfg_write) begin
				ws_q <= ws_new;
			end
			if (clear) begin
				fill_q  <= '0;
				wp_q    <= '0;
				sum_q   <= '0;
				min_q   <= '0;
				max_q   <= '0;
				total_q <= '0;
				count_q <= '0;
			end else begin
				if (cmd.update) begin
					if (full) begin
						sum_q <= sum_q - SUM_W'(old_sample_q) + SUM_W'(sample_q);
					end else begin
						sum_q  <= sum_q + SUM_W'(sample_q);
						fill_q <= fill_inc;
					end
					wp_q <= (wp_inc == ws_q) ? '0 : AW'(wp_inc);
				end
				if (cmd.record) begin
					// The first average of a batch seeds both extremes.
					if (count_q == '0) begin
						min_q <= div_quotient;
						max_q <= div_quotient;
					end else begin
						if (div_quotient < min_q) min_q <= div_quotient;
						if (div_quotient > max_q) max_q <= div_quotient;
					end
					if (count_q != COUNT_MAX) begin
						total_q <= total_q + TOTAL_BITS'(div_quotient);
						count_q <= count_q + 1'b1;
					end
				end
			end
		end
	end

	assign div_dividend = cmd.div_mean ? total_q : TOTAL_BITS'(sum_q);
	assign div_divisor  = cmd.div_mean ? count_q : COUNT_BITS'(ws_q);

	mas_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.average       <= avg_q;
			result_q.average_valid <= 1'b1;
			result_q.batch_min     <= last_q ? min_q : '0;
			result_q.batch_max     <= last_q ? max_q : '0;
			result_q.batch_mean    <= last_q ? div_quotient : '0;
			result_q.stats_valid   <= last_q;
		end
	end

	assign status.produce  = full || (fill_inc == ws_q) || last_q;
	assign status.last     = last_q;
	assign status.div_done = div_done;
	assign status.out_free = out_free;

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### design/mas_ctrl.sv
// Controller state machine that sequences one sample through the datapath.
`timescale 1ns / 1ps

module mas_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  mas_pkg::mas_status_t status,
	output mas_pkg::mas_cmd_t    cmd
);
	import mas_pkg::*;

	mas_state_t state_q;
	mas_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_next = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_next = status.produce ? ST_START_AVG : ST_IDLE;
			end
			ST_START_AVG: begin
				state_next = ST_DIV_AVG;
			end
			ST_DIV_AVG: begin
				if (status.div_done) state_next = ST_RECORD;
			end
			ST_RECORD: begin
				state_next = status.last ? ST_START_MEAN : ST_EMIT;
			end
			ST_START_MEAN: begin
				state_next = ST_DIV_MEAN;
			end
			ST_DIV_MEAN: begin
				if (status.div_done) state_next = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		item_ready = 1'b0;
		cfg_ready  = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				item_ready    = 1'b1;
				cfg_ready     = 1'b1;
				cmd.load_item = item_valid;
				cmd.cfg_write = cfg_valid;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
			end
			ST_START_AVG: begin
				cmd.div_start = 1'b1;
			end
			ST_RECORD: begin
				cmd.record = 1'b1;
			end
			ST_START_MEAN: begin
				cmd.div_start = 1'b1;
				cmd.div_mean  = 1'b1;
			end
			ST_DIV_MEAN: begin
				cmd.div_mean = 1'b1;
			end
			ST_EMIT: begin
				cmd.div_mean = 1'b1;
				cmd.emit     = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### design/moving_average_with_stats.sv
// Top level of the moving-average filter with per-batch statistics.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  cfg      | cfg_valid / cfg_ready   | cfg_data: window size, 0 reads as 1
//  item     | item_valid / item_ready | item: sample, batch_end
//  result   | result_valid / result_ready | result: average and batch statistics
//
// One item is processed at a time. A sample that yields no result passes only through
// the idle and update states; one that yields an average also runs the 32-step shared
// divider, and a batch end adds a second 32-step division for the mean.
// The result register lets the next item enter while a result waits for result_ready.
// Reset clears all control state; the sample ring needs no clearing pass.
`timescale 1ns / 1ps

module moving_average_with_stats #(
	parameter int WINDOW_MAX = mas_pkg::WINDOW_MAX_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mas_pkg::CFG_BITS-1:0] cfg_data,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  mas_pkg::item_t               item,
	output logic                         result_valid,
	input  logic                         result_ready,
	output mas_pkg::result_t             result
);
	import mas_pkg::*;

	mas_cmd_t    cmd;
	mas_status_t status;

	mas_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.status     (status),
		.cmd        (cmd)
	);

	mas_datapath #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.item         (item),
		.cfg_data     (cfg_data),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

### design/mas_checker.sv
// Port-level checker for the moving-average block and its bind statement.
`timescale 1ns / 1ps

module mas_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cfg_ready,
	input logic                         item_valid,
	input logic                         item_ready,
	input logic                         result_valid,
	input logic                         result_ready,
	input mas_pkg::result_t             result
);
	import mas_pkg::*;

	// A stalled result transaction keeps its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// After an item transaction the block is busy in the next cycle.
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready && !cfg_ready)
		else $error("item taken again without processing");

	// A result without statistics carries zero statistics fields.
	a_plain_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.stats_valid |->
		result.average_valid && result.batch_min == '0 &&
		result.batch_max == '0 && result.batch_mean == '0)
		else $error("statistics fields set on a plain result");

	// Batch statistics are ordered: min <= mean <= max.
	a_stats_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.stats_valid |->
		result.average_valid && result.batch_min <= result.batch_mean &&
		result.batch_mean <= result.batch_max)
		else $error("batch statistics out of order");

endmodule

bind moving_average_with_stats mas_checker u_mas_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_ready    (cfg_ready),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

### verif/tb_moving_average_with_stats.sv
// Self-checking testbench for the moving-average filter with per-batch statistics.
`timescale 1ns / 1ps

module tb_moving_average_with_stats;
	import mas_pkg::*;

	localparam int ITEM_TARGET = 800;
	localparam int SETTLE_CYCLES = 100;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_AFTER = 300;
	localparam int HOLD_CYCLES = 500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_BITS-1:0] cfg_data = CFG_BITS'(WS_RESET);
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;

	moving_average_with_stats dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	item_t pending_items[$];
	result_t expected_results[$];

	int errors = 0;
	int items_queued = 0;
	int items_sent = 0;
	int items_taken = 0;
	int results_got = 0;
	int cfg_writes = 0;
	int batches_closed = 0;
	int quiet_cycles = 0;
	int send_wait = 0;
	int send_streak = 0;
	int ready_wait = 0;
	int ready_streak = 0;
	int ready_mark = 0;
	int hold_count = 0;
	bit hold_done = 1'b0;

	// Filter state as the block should hold it.
	int win_len = WS_RESET;
	longint ring[WINDOW_MAX_DEF];
	int filled = 0;
	int wr_slot = 0;
	longint win_sum = 0;
	longint batch_lo = 0;
	longint batch_hi = 0;
	longint avg_total = 0;
	int avg_count = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int draw_wait(inout int streak);
		if (streak > 0) begin
			streak--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			streak = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 10);
	endfunction

	function automatic int draw_sample();
		case ($urandom_range(0, 9))
			0: return 32767;
			1: return -32768;
			2, 3, 4: return $urandom_range(0, 1000) - 500;
			default: return $signed(16'($urandom()));
		endcase
	endfunction

	task automatic clear_window();
		for (int i = 0; i < WINDOW_MAX_DEF; i++) ring[i] = 0;
		filled = 0;
		wr_slot = 0;
		win_sum = 0;
		batch_lo = 0;
		batch_hi = 0;
		avg_total = 0;
		avg_count = 0;
	endtask

	task automatic apply_window_size(input logic [CFG_BITS-1:0] value);
		int v;
		v = value;
		if (v == 0) v = 1;
		if (v > WINDOW_MAX_DEF) v = WINDOW_MAX_DEF;
		win_len = v;
		clear_window();
	endtask

	task automatic filter_step(input item_t it);
		longint s;
		longint avg;
		bit produce;
		result_t r;
		s = longint'($signed(it.sample));
		if (filled < win_len) begin
			win_sum += s;
			filled++;
			produce = (filled == win_len) || it.batch_end;
		end else begin
			win_sum = win_sum - ring[wr_slot] + s;
			produce = 1'b1;
		end
		ring[wr_slot] = s;
		wr_slot = (wr_slot + 1) % win_len;
		if (!produce) return;
		avg = win_sum / win_len;
		if (avg_count == 0) begin
			batch_lo = avg;
			batch_hi = avg;
		end else begin
			if (avg < batch_lo) batch_lo = avg;
			if (avg > batch_hi) batch_hi = avg;
		end
		// The mean freezes once the count saturates; min and max keep tracking.
		if (avg_count < int'(COUNT_MAX)) begin
			avg_total += avg;
			avg_count++;
		end
		r = '0;
		r.average = 16'(avg);
		r.average_valid = 1'b1;
		if (it.batch_end) begin
			r.batch_min = 16'(batch_lo);
			r.batch_max = 16'(batch_hi);
			r.batch_mean = 16'(avg_total / avg_count);
			r.stats_valid = 1'b1;
			batches_closed++;
			clear_window();
		end
		expected_results.push_back(r);
	endtask

	task automatic check_result(input result_t got);
		result_t exp;
		if (expected_results.size() == 0) begin
			if (errors < 10)
				$display("Unexpected result transaction: avg=%0d min=%0d max=%0d mean=%0d",
					$signed(got.average), $signed(got.batch_min),
					$signed(got.batch_max), $signed(got.batch_mean));
			errors++;
			return;
		end
		exp = expected_results.pop_front();
		if (got.average !== exp.average || got.average_valid !== exp.average_valid ||
				got.batch_min !== exp.batch_min || got.batch_max !== exp.batch_max ||
				got.batch_mean !== exp.batch_mean || got.stats_valid !== exp.stats_valid) begin
			if (errors < 10) begin
				$display("Result %0d expected avg=%0d v=%0b min=%0d max=%0d mean=%0d s=%0b",
					results_got, $signed(exp.average), exp.average_valid,
					$signed(exp.batch_min), $signed(exp.batch_max),
					$signed(exp.batch_mean), exp.stats_valid);
				$display("Result %0d got      avg=%0d v=%0b min=%0d max=%0d mean=%0d s=%0b",
					results_got, $signed(got.average), got.average_valid,
					$signed(got.batch_min), $signed(got.batch_max),
					$signed(got.batch_mean), got.stats_valid);
			end
			errors++;
		end
	endtask

	// Monitor: every accepted transaction is sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				check_result(result);
				results_got <= results_got + 1;
			end
			if (item_valid && item_ready) begin
				filter_step(item);
				items_taken <= items_taken + 1;
			end
			if (cfg_valid && cfg_ready) begin
				apply_window_size(cfg_data);
				cfg_writes <= cfg_writes + 1;
			end
		end
	end

	// Driver: presents queued samples with a random gap after each accepted one.
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || items_taken == items_sent) begin
			if (send_wait > 0) begin
				send_wait--;
				item_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				item <= pending_items.pop_front();
				item_valid <= 1'b1;
				items_sent++;
				send_wait = draw_wait(send_streak);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Result sink: a random stall after each result, plus the long hold-off.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (results_got != ready_mark) begin
				ready_mark = results_got;
				ready_wait = draw_wait(ready_streak);
			end
			if (hold_count > 0) begin
				result_ready <= 1'b0;
			end else if (ready_wait > 0) begin
				ready_wait--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Once, the sink refuses results long enough that the block backs up into its input.
	always @(posedge clk) begin
		if (hold_count > 0) begin
			hold_count <= hold_count - 1;
		end else if (!hold_done && items_taken >= HOLD_AFTER) begin
			hold_count <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_item(input int s, input bit last);
		item_t it;
		it.sample = 16'(s);
		it.batch_end = last;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// Waits until every sample has been taken and every result checked, then lets the
	// block finish any sample that yields no result.
	task automatic settle();
		while (items_taken != items_queued || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [CFG_BITS-1:0] value);
		int mark;
		mark = cfg_writes;
		@(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (cfg_writes == mark);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [CFG_BITS-1:0] value, input int n);
		int stop_at;
		int len;
		settle();
		write_window(value);
		stop_at = items_queued + n;
		while (items_queued < stop_at) begin
			// Some batches end before the window has filled.
			if ($urandom_range(0, 4) == 0)
				len = $urandom_range(1, win_len);
			else
				len = $urandom_range(win_len, 3 * win_len + 4);
			for (int k = 1; k <= len; k++)
				queue_item(draw_sample(), k == len);
		end
		// Sometimes leave a batch open so the next register write has to clear it.
		if ($urandom_range(0, 1) == 0) begin
			len = $urandom_range(1, 2 * win_len);
			for (int k = 0; k < len; k++)
				queue_item(draw_sample(), 1'b0);
		end
	endtask

	initial begin
		clear_window();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed samples at the reset window size of three.
		queue_item(32767, 1'b0);
		queue_item(32767, 1'b0);
		queue_item(32767, 1'b0);
		queue_item(-32768, 1'b0);
		queue_item(-32768, 1'b0);
		queue_item(-32768, 1'b1);
		queue_item(5, 1'b1);
		queue_item(-7, 1'b0);
		queue_item(0, 1'b1);
		queue_item(-1, 1'b0);
		queue_item(-1, 1'b0);
		queue_item(0, 1'b1);
		queue_item(100, 1'b0);
		queue_item(-100, 1'b0);
		queue_item(50, 1'b0);
		queue_item(60, 1'b0);
		queue_item(70, 1'b1);
		queue_item(-5, 1'b0);
		queue_item(-6, 1'b0);

		// Register extremes: zero reads as one, anything above the maximum saturates.
		run_phase(7'd0, 60);
		run_phase(7'd127, 150);
		run_phase(7'd65, 30);
		run_phase(7'd2, 80);
		run_phase(7'd64, 80);
		run_phase(7'd1, 20);
		while (items_queued < ITEM_TARGET) begin
			if ($urandom_range(0, 3) == 0)
				run_phase(7'($urandom_range(0, 127)), $urandom_range(40, 90));
			else
				run_phase(7'($urandom_range(1, 8)), $urandom_range(40, 90));
		end
		settle();

		$display("Covered %0d samples and %0d results, %0d closing a batch, over %0d writes",
			items_taken, results_got, batches_closed, cfg_writes);
		$display("of the window size, with random gaps, sink stalls and one long hold-off.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
